// ===== hw/rtl/thgps_pkg.sv =====
// Package for the two-head granular pitch shifter.
// Holds the sample transaction types, register indexes and fixed-point constants.
// No dependencies.
package thgps_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RATIO_W   = 19;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = RATIO_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 1'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 19'd65536;

  // Q2.30 constants used when building the window ROM
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } thgps_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } thgps_out_t;

endpackage

// ===== hw/rtl/two_head_granular_pitch_shifter_unit.sv =====
// Two-head granular pitch shifter, top level.
// Capture memory, window ROM, shared multiplier and its sequencer.
// Depends on thgps_pkg.
//
// Usage
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one stereo Q1.23
//   pair per transaction; the output channel carries one stereo pair back per
//   input transaction, in order. Configuration (bypass, pitch ratio in Q3.16)
//   is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle.
// Operation
//   Bypass: the pair lands in the output register on the accepting edge, so
//   a new pair can be taken whenever the output register is free.
//   Shifting: no new transaction is taken until the sequencer is back in idle.
//   The work is serial because of the single multiplier: each head needs two
//   memory reads, then for each channel a difference multiply, an
//   interpolation add and a window multiply, all through the same unit.
// Reset
//   Registers return to bypass with unity ratio. A clearing pass writes zero to
//   every one of the BUF_SIZE entries (8192 by default) of the capture memory;
//   no sample is taken until it ends, configuration writes are taken throughout.
// Stall
//   A result waits in the output register. A bypass pair is still accepted
//   whenever the register frees in that cycle; a shifting transaction runs
//   and holds its result in the sequencer until the register is free.
module two_head_granular_pitch_shifter_unit #(
  parameter int unsigned BUF_SIZE   = 8192,
  parameter int unsigned GRAIN_SIZE = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  thgps_pkg::thgps_in_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output thgps_pkg::thgps_out_t            out_data_o,
  input  logic                             cfg_we_i,
  input  logic [thgps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [thgps_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import thgps_pkg::*;

  localparam int unsigned AW   = $clog2(BUF_SIZE);
  localparam int unsigned GW   = $clog2(GRAIN_SIZE);
  localparam int unsigned HMAX = (BUF_SIZE > GRAIN_SIZE / 2) ? BUF_SIZE : GRAIN_SIZE / 2;
  localparam int unsigned HIW  = $clog2(HMAX + 9);
  localparam int unsigned ROW_W = 2 * SAMPLE_W;

  localparam logic [HIW-1:0] BUF_H    = HIW'(BUF_SIZE);
  localparam logic [AW:0]    BUF_A    = (AW + 1)'(BUF_SIZE);
  localparam logic [AW-1:0]  BUF_LAST = AW'(BUF_SIZE - 1);
  localparam logic [GW:0]    GRAIN_G  = (GW + 1)'(GRAIN_SIZE);
  localparam logic [GW:0]    BUF_MODG = (GW + 1)'(BUF_SIZE % GRAIN_SIZE);
  localparam logic [HIW-1:0] HB_INT0  = HIW'(GRAIN_SIZE / 2);
  localparam logic [AW-1:0]  HB_BIDX0 = AW'((GRAIN_SIZE / 2) % BUF_SIZE);
  localparam logic [GW-1:0]  HB_WIDX0 = GW'(GRAIN_SIZE / 2);

  localparam logic signed [57:0] RND_HALF = 58'sd1 <<< 31;
  localparam logic signed [25:0] SAT_MAX  = 26'sd8388607;
  localparam logic signed [25:0] SAT_MIN  = -26'sd8388608;

  // sequencer states
  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_WRS  = 4'd2;
  localparam logic [3:0] ST_RD0  = 4'd3;
  localparam logic [3:0] ST_RD1  = 4'd4;
  localparam logic [3:0] ST_MDL  = 4'd5;
  localparam logic [3:0] ST_ITL  = 4'd6;
  localparam logic [3:0] ST_MWL  = 4'd7;
  localparam logic [3:0] ST_MDR  = 4'd8;
  localparam logic [3:0] ST_ITR  = 4'd9;
  localparam logic [3:0] ST_MWR  = 4'd10;
  localparam logic [3:0] ST_ACR  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  // Hann window, sin^2 via a truncating odd Taylor series in Q2.30
  typedef logic [15:0] win_rom_t [GRAIN_SIZE];

  function automatic win_rom_t build_win();
    win_rom_t    rom;
    logic [63:0] m, x, x2, t, s, s2;
    for (int n = 0; n < GRAIN_SIZE; n++) begin
      m  = (64'(2 * n) > 64'(GRAIN_SIZE - 1)) ? 64'(GRAIN_SIZE - 1 - n) : 64'(n);
      x  = (PI_Q30 * m) / 64'(GRAIN_SIZE - 1);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      s2 = (s * s) >> 30;
      rom[n] = 16'((s2 * 64'd65535 + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam win_rom_t WIN_ROM = build_win();

  function automatic logic [SAMPLE_W-1:0] sat24(logic signed [25:0] q);
    logic [SAMPLE_W-1:0] r;
    if (q > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (q < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic               bypass_q;
  logic [RATIO_W-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      ratio_q  <= RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BYPASS: bypass_q <= cfg_wdata_i[0];
        CFG_RATIO:  ratio_q  <= cfg_wdata_i[RATIO_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [3:0]            st_q, st_d;
  logic                  hd_q;
  logic [AW-1:0]         clr_q;
  logic [AW-1:0]         wp_q;
  thgps_in_t             smp_q;
  logic [HIW-1:0]        hint_q  [2];
  logic [FRAC_W-1:0]     hfrac_q [2];
  logic [AW-1:0]         hbidx_q [2];
  logic [GW-1:0]         hwidx_q [2];
  logic [ROW_W-1:0]      rd_q;
  logic [ROW_W-1:0]      s0_q;
  logic [15:0]           win_q;
  logic signed [57:0]    p_q;
  logic signed [40:0]    ip_q;
  logic signed [57:0]    acc_l_q, acc_r_q;
  thgps_out_t            out_q;
  logic                  out_vld_q;

  logic in_acc, out_free, ld_bp, ld_fin;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && (!bypass_q || out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ld_bp      = in_acc && bypass_q;
  assign ld_fin     = (st_q == ST_FIN) && out_free;

  // current head views
  logic [HIW-1:0]    cur_int;
  logic [FRAC_W-1:0] cur_frac;
  logic [AW-1:0]     cur_bidx, nxt_bidx;
  logic [GW-1:0]     cur_widx;

  assign cur_int  = hint_q[hd_q];
  assign cur_frac = hfrac_q[hd_q];
  assign cur_bidx = hbidx_q[hd_q];
  assign cur_widx = hwidx_q[hd_q];
  assign nxt_bidx = (cur_bidx == BUF_LAST) ? '0 : cur_bidx + 1'b1;

  // head advance by the pitch ratio
  logic [19:0]       sumf;
  logic [3:0]        delta;
  logic [HIW-1:0]    int_raw, int_new;
  logic              wrap;
  logic [AW:0]       bidx_raw, bidx_adj;
  logic [GW:0]       widx_raw, widx_m, widx_adj;

  always_comb begin
    sumf     = {4'b0, cur_frac} + {1'b0, ratio_q};
    delta    = sumf[19:16];
    int_raw  = cur_int + HIW'(delta);
    wrap     = int_raw >= BUF_H;
    int_new  = wrap ? int_raw - BUF_H : int_raw;
    bidx_raw = {1'b0, cur_bidx} + (AW + 1)'(delta);
    bidx_adj = (bidx_raw >= BUF_A) ? bidx_raw - BUF_A : bidx_raw;
    widx_raw = {1'b0, cur_widx} + (GW + 1)'(delta);
    widx_m   = (widx_raw >= GRAIN_G) ? widx_raw - GRAIN_G : widx_raw;
    // a wrap of the position by BUF_SIZE moves the window phase too
    if (!wrap) begin
      widx_adj = widx_m;
    end else if (widx_m >= BUF_MODG) begin
      widx_adj = widx_m - BUF_MODG;
    end else begin
      widx_adj = widx_m + GRAIN_G - BUF_MODG;
    end
  end

  // sample rows: left in the upper half
  logic signed [SAMPLE_W-1:0] s0l, s0r, s1l, s1r;
  logic signed [24:0]         dl, dr;

  assign s0l = s0_q[ROW_W-1:SAMPLE_W];
  assign s0r = s0_q[SAMPLE_W-1:0];
  assign s1l = rd_q[ROW_W-1:SAMPLE_W];
  assign s1r = rd_q[SAMPLE_W-1:0];
  assign dl  = {s1l[SAMPLE_W-1], s1l} - {s0l[SAMPLE_W-1], s0l};
  assign dr  = {s1r[SAMPLE_W-1], s1r} - {s0r[SAMPLE_W-1], s0r};

  // shared multiplier
  logic signed [40:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [57:0] mul_p;

  always_comb begin
    unique case (st_q)
      ST_MDL: begin
        mul_a = {{16{dl[24]}}, dl};
        mul_b = {1'b0, cur_frac};
      end
      ST_MDR: begin
        mul_a = {{16{dr[24]}}, dr};
        mul_b = {1'b0, cur_frac};
      end
      default: begin
        mul_a = ip_q;
        mul_b = {1'b0, win_q};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // capture memory port
  logic [ROW_W-1:0] mem [BUF_SIZE];
  logic             mem_we, rd_en;
  logic [AW-1:0]    mem_addr;
  logic [ROW_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur_bidx;
    mem_wdata = smp_q;
    unique case (st_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ST_WRS: begin
        mem_we   = 1'b1;
        mem_addr = wp_q;
      end
      ST_RD1:  mem_addr = nxt_bidx;
      default: ;
    endcase
  end

  assign rd_en = (st_q == ST_RD0) || (st_q == ST_RD1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_RD0) begin
      win_q <= WIN_ROM[cur_widx];
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLR:  if (clr_q == BUF_LAST) st_d = ST_IDLE;
      ST_IDLE: if (in_acc && !bypass_q) st_d = ST_WRS;
      ST_WRS:  st_d = ST_RD0;
      ST_RD0:  st_d = ST_RD1;
      ST_RD1:  st_d = ST_MDL;
      ST_MDL:  st_d = ST_ITL;
      ST_ITL:  st_d = ST_MWL;
      ST_MWL:  st_d = ST_MDR;
      ST_MDR:  st_d = ST_ITR;
      ST_ITR:  st_d = ST_MWR;
      ST_MWR:  st_d = ST_ACR;
      ST_ACR:  st_d = hd_q ? ST_FIN : ST_RD0;
      ST_FIN:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_CLR;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_CLR;
      hd_q       <= 1'b0;
      clr_q      <= '0;
      wp_q       <= '0;
      hint_q[0]  <= '0;
      hfrac_q[0] <= '0;
      hbidx_q[0] <= '0;
      hwidx_q[0] <= '0;
      hint_q[1]  <= HB_INT0;
      hfrac_q[1] <= '0;
      hbidx_q[1] <= HB_BIDX0;
      hwidx_q[1] <= HB_WIDX0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc) begin
        hd_q <= 1'b0;
      end
      if (st_q == ST_WRS) begin
        wp_q <= (wp_q == BUF_LAST) ? '0 : wp_q + 1'b1;
      end
      if (st_q == ST_ACR) begin
        hint_q[hd_q]  <= int_new;
        hfrac_q[hd_q] <= sumf[FRAC_W-1:0];
        hbidx_q[hd_q] <= bidx_adj[AW-1:0];
        hwidx_q[hd_q] <= widx_adj[GW-1:0];
        hd_q          <= 1'b1;
      end
      if (ld_bp || ld_fin) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q   <= in_data_i;
      acc_l_q <= RND_HALF;
      acc_r_q <= RND_HALF;
    end
    if (st_q == ST_RD1) begin
      s0_q <= rd_q;
    end
    if (st_q == ST_MDL || st_q == ST_MWL || st_q == ST_MDR || st_q == ST_MWR) begin
      p_q <= mul_p;
    end
    // interpolation: s0 * 2^16 + (s1 - s0) * frac
    if (st_q == ST_ITL) begin
      ip_q <= {s0l[SAMPLE_W-1], s0l, 16'h0} + p_q[40:0];
    end
    if (st_q == ST_ITR) begin
      ip_q <= {s0r[SAMPLE_W-1], s0r, 16'h0} + p_q[40:0];
    end
    if (st_q == ST_MDR) begin
      acc_l_q <= acc_l_q + p_q;
    end
    if (st_q == ST_ACR) begin
      acc_r_q <= acc_r_q + p_q;
    end
    if (ld_bp) begin
      out_q.out_left  <= in_data_i.in_left;
      out_q.out_right <= in_data_i.in_right;
    end else if (ld_fin) begin
      // rounding half was preloaded into the accumulators
      out_q.out_left  <= sat24(acc_l_q[57:32]);
      out_q.out_right <= sat24(acc_r_q[57:32]);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for two_head_granular_pitch_shifter_unit.
// Queue-fed driver, clocked monitor and an in-bench pitch shifter predictor.
// Depends on thgps_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thgps_pkg::*;

  localparam int unsigned BUF_SIZE   = 8192;
  localparam int unsigned GRAIN_SIZE = 2048;
  localparam longint     SAMPLE_MAX  = 64'sd8388607;
  localparam longint     SAMPLE_MIN  = -64'sd8388608;
  localparam logic [CFG_W-1:0] RATIO_MAX = 19'd524287;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam longint unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  thgps_in_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  thgps_out_t           out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predictor state
  logic                      cfg_bypass;
  logic [CFG_W-1:0]          cfg_ratio;
  logic signed [SAMPLE_W-1:0] left_mem  [BUF_SIZE];
  logic signed [SAMPLE_W-1:0] right_mem [BUF_SIZE];
  logic [15:0]               hann_rom  [GRAIN_SIZE];
  int unsigned               wr_ptr;
  logic [31:0]               head_a;
  logic [31:0]               head_b;

  thgps_in_t  sample_q [$];
  thgps_out_t shifted_q [$];
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 45;
  int unsigned err_cnt = 0;
  longint unsigned cycle_cnt = 0;

  two_head_granular_pitch_shifter_unit #(
    .BUF_SIZE   (BUF_SIZE),
    .GRAIN_SIZE (GRAIN_SIZE)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hann window, sin^2 from a truncating odd Taylor series in Q2.30
  function automatic void build_hann_rom();
    logic [63:0] den, nn, m, x, x2, t, s, s2;
    den = GRAIN_SIZE - 1;
    for (int n = 0; n < GRAIN_SIZE; n++) begin
      nn = n;
      m  = (2 * nn > den) ? den - nn : nn;
      x  = (PI_Q30 * m) / den;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int k = 0; k < 7; k++) begin
        t = Q30_ONE - ((x2 * t) >> 30) / ((15 - 2 * k) * (14 - 2 * k));
      end
      s = (x * t) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      s2 = (s * s) >> 30;
      hann_rom[n] = 16'((s2 * 64'd65535 + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic void reset_shifter();
    cfg_bypass = 1'b1;
    cfg_ratio  = RATIO_RESET;
    for (int i = 0; i < BUF_SIZE; i++) begin
      left_mem[i]  = '0;
      right_mem[i] = '0;
    end
    wr_ptr = 0;
    head_a = '0;
    head_b = (GRAIN_SIZE / 2) << FRAC_W;
  endfunction

  function automatic longint lerp_read(logic use_left, logic [31:0] pos);
    int unsigned idx, nxt;
    longint f, a, b;
    idx = (pos >> FRAC_W) % BUF_SIZE;
    nxt = (idx + 1) % BUF_SIZE;
    f   = pos[FRAC_W-1:0];
    a   = use_left ? left_mem[idx] : right_mem[idx];
    b   = use_left ? left_mem[nxt] : right_mem[nxt];
    return a * ((64'sd1 << FRAC_W) - f) + b * f;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] round_sat(longint acc);
    longint q;
    q = (acc + (64'sd1 << 31)) >>> 32;
    if (q > SAMPLE_MAX) q = SAMPLE_MAX;
    if (q < SAMPLE_MIN) q = SAMPLE_MIN;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic [31:0] step_head(logic [31:0] pos);
    logic [31:0] p;
    p = pos + cfg_ratio;
    if ((p >> FRAC_W) >= BUF_SIZE) p = p - (BUF_SIZE << FRAC_W);
    return p;
  endfunction

  function automatic thgps_out_t shift_sample(thgps_in_t s);
    thgps_out_t r;
    longint wa, wb;
    if (cfg_bypass) begin
      r.out_left  = s.in_left;
      r.out_right = s.in_right;
      return r;
    end
    left_mem[wr_ptr]  = s.in_left;
    right_mem[wr_ptr] = s.in_right;
    wa = hann_rom[(head_a >> FRAC_W) % GRAIN_SIZE];
    wb = hann_rom[(head_b >> FRAC_W) % GRAIN_SIZE];
    r.out_left  = round_sat(lerp_read(1'b1, head_a) * wa + lerp_read(1'b1, head_b) * wb);
    r.out_right = round_sat(lerp_read(1'b0, head_a) * wa + lerp_read(1'b0, head_b) * wb);
    wr_ptr = (wr_ptr + 1) % BUF_SIZE;
    head_a = step_head(head_a);
    head_b = step_head(head_b);
    return r;
  endfunction

  // driver: a new transaction only once the previous one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    thgps_out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (shifted_q.size() == 0) begin
          $error("result transaction with none expected: %0d %0d",
                 out_data.out_left, out_data.out_right);
          err_cnt++;
        end else begin
          want = shifted_q.pop_front();
          if (out_data.out_left !== want.out_left) begin
            $error("out_left: expected %0d, got %0d", want.out_left, out_data.out_left);
            err_cnt++;
          end
          if (out_data.out_right !== want.out_right) begin
            $error("out_right: expected %0d, got %0d", want.out_right, out_data.out_right);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) shifted_q.push_back(shift_sample(in_data));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("two_head_granular_pitch_shifter_unit regression: fail");
      $finish;
    end
  end

  task automatic push_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    thgps_in_t s;
    s.in_left  = l;
    s.in_right = r;
    sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || shifted_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_BYPASS) cfg_bypass = val[0];
    else cfg_ratio = val;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      1: return 24'($signed(12'($urandom)));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_ratio();
    case ($urandom_range(9))
      0: return RATIO_MAX;
      1: return 19'd1;
      2, 3: return 19'($urandom_range(524287, 1));
      default: return 19'($urandom_range(131072, 32768));
    endcase
  endfunction

  initial begin
    int unsigned sent, n;
    build_hann_rom();
    reset_shifter();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bypass out of reset: pass-through of extremes
    push_pair(24'sh7fffff, 24'sh800000);
    push_pair(24'sh800000, 24'sh7fffff);
    push_pair(24'sh000000, -24'sd1);
    push_pair(24'sh555555, 24'shaaaaaa);
    drain();

    // unity ratio, full-scale content
    write_reg(CFG_BYPASS, '0);
    push_pair(24'sh7fffff, 24'sh7fffff);
    push_pair(24'sh800000, 24'sh800000);
    push_pair(24'sh7fffff, 24'sh800000);
    push_pair(24'sh800000, 24'sh7fffff);
    push_pair(24'sh000001, -24'sd1);
    push_pair(24'shaaaaaa, 24'sh555555);
    drain();

    // frozen heads
    write_reg(CFG_RATIO, '0);
    push_pair(24'sh7fffff, 24'sh123456);
    push_pair(24'sh800000, -24'sd77);
    push_pair(24'sh000000, 24'sh7fffff);
    drain();

    // fastest heads
    write_reg(CFG_RATIO, RATIO_MAX);
    for (int i = 0; i < 5; i++) push_pair(i[0] ? 24'sh7fffff : 24'sh800000, rand_sample());
    drain();

    write_reg(CFG_RATIO, 19'd1);
    for (int i = 0; i < 3; i++) push_pair(rand_sample(), rand_sample());
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 16;
      end
      write_reg(CFG_BYPASS, ($urandom_range(99) < 12) ? 19'd1 : 19'd0);
      write_reg(CFG_RATIO, rand_ratio());
      n = $urandom_range(80, 10);
      for (int i = 0; i < n; i++) push_pair(rand_sample(), rand_sample());
      sent += n;
      // sender held off until every result is back
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("two_head_granular_pitch_shifter_unit regression: pass");
    end else begin
      $display("two_head_granular_pitch_shifter_unit regression: fail");
    end
    $finish;
  end

endmodule
